@@ hdl/utp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utp_pkg
// Shared constants, types and helpers of the UUID text parser.
// ----------------------------------------------------------------------------
package utp_pkg;

  localparam int unsigned PosWidth   = 6;
  localparam int unsigned CountWidth = 5;

  localparam logic [PosWidth-1:0]   LenDashed   = 6'd36;
  localparam logic [PosWidth-1:0]   LenPlain    = 6'd32;
  localparam logic [PosWidth-1:0]   PosSaturate = 6'd37;
  localparam logic [PosWidth-1:0]   PosFormat   = 6'd8;
  localparam logic [PosWidth-1:0]   PosDashA    = 6'd13;
  localparam logic [PosWidth-1:0]   PosDashB    = 6'd18;
  localparam logic [PosWidth-1:0]   PosDashC    = 6'd23;
  localparam logic [CountWidth-1:0] UuidBytes   = 5'd16;
  localparam logic [7:0]            DashChar    = 8'h2D;

  // Result queue between the parser and the output stage
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // One result item as produced by the parser; the output stage folds the
  // check flags into the final status.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [3:0] byte_index;
    logic       done_res;
    logic       error_seen;
    logic       length_bad;
    logic       count_bad;
    logic       odd_digit;
  } event_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] ch);
    hex_t h;
    h.is_hex = 1'b1;
    h.nibble = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      h.nibble = ch[3:0];
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      // 'a'..'f' and 'A'..'F' share the low three bits: 1..6
      h.nibble = 4'd9 + {1'b0, ch[2:0]};
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ hdl/utp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utp_in_if / utp_out_if
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
interface utp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       final_char;

  modport source (output valid, output character, output final_char, input ready);
  modport sink (input valid, input character, input final_char, output ready);
endinterface

interface utp_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic [3:0] byte_index;
  logic       done_res;
  logic       status;

  modport source (
    output valid, output byte_valid, output byte_value, output byte_index,
    output done_res, output status, input ready
  );
  modport sink (
    input valid, input byte_valid, input byte_value, input byte_index,
    input done_res, input status, output ready
  );
endinterface

@@ hdl/uuid_text_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uuid_text_parser
// Streaming parser for the text form of a UUID, dashed or plain.
// ----------------------------------------------------------------------------
// Takes one character per clock cycle while input ready is high, with
// final_char on the last character of each string. The parser updates its
// state in the same cycle it takes a character and drops a result into a
// four-entry queue, which the output register loads from when it is empty
// or being taken. Input ready falls only when the queue is full, i.e. when
// the output side has stalled long enough. A result is produced for each
// byte decoded before any error (byte_valid, with its index 0..15) and for
// the last character (done_res, status 0 if well-formed, 1 otherwise); other
// characters produce nothing. Parse state clears after every string.
// ----------------------------------------------------------------------------
module uuid_text_parser (
  input  logic       clk,
  input  logic       rst,
  utp_in_if.sink     in_ch,
  utp_out_if.source  out_ch
);

  utp_pkg::event_t front_event;
  utp_pkg::event_t queue_event;
  logic            push;
  logic            room;
  logic            pop;
  logic            avail;

  utp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .valid      (in_ch.valid),
    .ready      (in_ch.ready),
    .character  (in_ch.character),
    .final_char (in_ch.final_char),
    .room       (room),
    .push       (push),
    .event_out  (front_event)
  );

  utp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_event),
    .room      (room),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (queue_event)
  );

  utp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .avail    (avail),
    .event_in (queue_event),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

@@ hdl/utp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utp_front
// Character classifier and parse state; emits one event per byte completed
// without error, or per final character.
// ----------------------------------------------------------------------------
module utp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid,
  output logic            ready,
  input  logic [7:0]      character,
  input  logic            final_char,
  input  logic            room,
  output logic            push,
  output utp_pkg::event_t event_out
);

  logic [utp_pkg::PosWidth-1:0]   char_position, char_position_next;
  logic [3:0]                     high_nibble, high_nibble_next;
  logic                           have_high, have_high_next;
  logic                           dashed_form, dashed_form_next;
  logic                           error_seen, error_seen_next;
  logic [utp_pkg::CountWidth-1:0] bytes_done, bytes_done_next;

  utp_pkg::hex_t                  hex;
  logic                           is_dash;
  logic                           at_format;
  logic                           at_dash_pos;
  logic                           dash_slot;
  logic                           digit_slot;
  logic                           pair;
  logic                           bytes_full;
  logic                           byte_out;
  logic                           accept;
  logic [utp_pkg::PosWidth-1:0]   want_len;

  assign ready  = room;
  assign accept = valid && ready;

  always_comb begin
    hex         = utp_pkg::hex_decode(character);
    is_dash     = (character == utp_pkg::DashChar);
    at_format   = (char_position == utp_pkg::PosFormat);
    at_dash_pos = (char_position == utp_pkg::PosDashA) ||
                  (char_position == utp_pkg::PosDashB) ||
                  (char_position == utp_pkg::PosDashC);

    dashed_form_next = at_format ? is_dash : dashed_form;
    dash_slot        = at_format ? is_dash : (dashed_form && at_dash_pos);
    digit_slot       = !dash_slot && hex.is_hex;
    pair             = digit_slot && have_high;
    bytes_full       = (bytes_done >= utp_pkg::UuidBytes);
    byte_out         = pair && !bytes_full && !error_seen;

    error_seen_next = error_seen ||
                      (!at_format && dash_slot && !is_dash) ||
                      (!dash_slot && !hex.is_hex) ||
                      (pair && bytes_full);
    bytes_done_next = (pair && !bytes_full) ? bytes_done + 1'b1 : bytes_done;
    have_high_next  = digit_slot ? !have_high : have_high;
    high_nibble_next = (digit_slot && !have_high) ? hex.nibble : high_nibble;
    char_position_next = (char_position < utp_pkg::PosSaturate) ?
                         char_position + 1'b1 : utp_pkg::PosSaturate;

    want_len = dashed_form_next ? utp_pkg::LenDashed : utp_pkg::LenPlain;

    event_out.byte_valid = byte_out;
    event_out.byte_value = byte_out ? {high_nibble, hex.nibble} : 8'd0;
    event_out.byte_index = byte_out ? bytes_done[3:0] : 4'd0;
    event_out.done_res   = final_char;
    // saturated position differs from the true length only past 37
    event_out.error_seen = final_char && error_seen_next;
    event_out.length_bad = final_char && (char_position_next != want_len);
    event_out.count_bad  = final_char && (bytes_done_next != utp_pkg::UuidBytes);
    event_out.odd_digit  = final_char && have_high_next;

    push = accept && (byte_out || final_char);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && final_char)) begin
      char_position <= '0;
      high_nibble   <= '0;
      have_high     <= 1'b0;
      dashed_form   <= 1'b0;
      error_seen    <= 1'b0;
      bytes_done    <= '0;
    end else if (accept) begin
      char_position <= char_position_next;
      high_nibble   <= high_nibble_next;
      have_high     <= have_high_next;
      dashed_form   <= dashed_form_next;
      error_seen    <= error_seen_next;
      bytes_done    <= bytes_done_next;
    end
  end

  a_bytes_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_done <= utp_pkg::UuidBytes)
    else $error("byte count ran past sixteen");

  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    accept && final_char |=> char_position == '0 && !have_high && !error_seen)
    else $error("parse state not cleared after the last character");

  a_no_byte_after_error: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> !event_out.byte_valid)
    else $error("byte emitted after an error");

  // the last character clears the count instead
  a_index_follows_count: assert property (@(posedge clk) disable iff (rst)
    push && event_out.byte_valid && !final_char |=>
      bytes_done == $past(bytes_done) + 1'b1)
    else $error("byte count did not advance with an emitted byte");

endmodule

@@ hdl/utp_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utp_fifo
// Short queue of parse events between the parser and the output stage.
// ----------------------------------------------------------------------------
module utp_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  utp_pkg::event_t push_data,
  output logic            room,
  input  logic            pop,
  output logic            avail,
  output utp_pkg::event_t pop_data
);

  utp_pkg::event_t                entries [utp_pkg::QueueDepth];
  logic [utp_pkg::QueuePtrW-1:0]  wr_ptr;
  logic [utp_pkg::QueuePtrW-1:0]  rd_ptr;
  logic [utp_pkg::QueueCntW-1:0]  count;
  logic                           do_pop;

  assign room     = (count != utp_pkg::QueueCntW'(utp_pkg::QueueDepth));
  assign avail    = (count != '0);
  assign pop_data = entries[rd_ptr];
  assign do_pop   = pop && avail;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("push into a full queue");

  a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (rst)
    count[utp_pkg::QueuePtrW-1:0] == wr_ptr - rd_ptr)
    else $error("queue count disagrees with pointers");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= utp_pkg::QueueCntW'(utp_pkg::QueueDepth))
    else $error("queue count above depth");

endmodule

@@ hdl/utp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utp_back
// Output stage: takes events off the queue, folds the end-of-string checks
// into the status and holds the result item until it is taken.
// ----------------------------------------------------------------------------
module utp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            avail,
  input  utp_pkg::event_t event_in,
  output logic            pop,
  utp_out_if.source       out_ch
);

  logic       out_valid;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic [3:0] byte_index;
  logic       done_res;
  logic       status;
  logic       status_next;

  assign pop = avail && (!out_valid || out_ch.ready);

  assign status_next = event_in.done_res &&
                       (event_in.error_seen || event_in.length_bad ||
                        event_in.count_bad || event_in.odd_digit);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_valid <= event_in.byte_valid;
      byte_value <= event_in.byte_value;
      byte_index <= event_in.byte_index;
      done_res   <= event_in.done_res;
      status     <= status_next;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.byte_valid = byte_valid;
  assign out_ch.byte_value = byte_value;
  assign out_ch.byte_index = byte_index;
  assign out_ch.done_res   = done_res;
  assign out_ch.status     = status;

  a_status_only_when_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> done_res)
    else $error("status flagged on an item that does not end a string");

  a_item_not_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_valid || done_res)
    else $error("result item carries neither a byte nor an end");

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped event not presented");

endmodule

@@ tb/uuid_text_parser_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uuid_text_parser_test
// Self-checking bench for the streaming UUID text parser.
// ----------------------------------------------------------------------------
// A short scripted sequence (bad characters, short strings, a bad format
// character) is followed by random strings: mostly well-formed dashed and
// plain UUIDs with random hex case, plus mutated strings and random noise.
// Expected result items, from a parser model or typed script rows, are checked
// in order. Both channels idle at random, and once the output side
// holds off long enough for the block to back up and drop its input ready.
// ----------------------------------------------------------------------------
module uuid_text_parser_test;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

  localparam int NumItems    = 1950;
  localparam int QuietFrom   = 300;
  localparam int QuietTo     = 700;
  localparam int HoldAt      = 400;
  localparam int HoldCycles  = 80;
  localparam int MaxReported = 10;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [3:0] byte_index;
    logic       done_res;
    logic       status;
  } parse_res_t;

  typedef enum bit {RowPredicted, RowTyped} row_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    row_kind_t  kind;
    parse_res_t res;
  } script_row_t;

  localparam int ScriptLen = 22;

  // Typed rows carry their result; the rest go through the parser model.
  script_row_t script [ScriptLen] = '{
    '{8'h00, 1'b1, RowTyped,     '{1'b0, 8'h00, 4'd0, 1'b1, StatusBad}},
    '{8'hFF, 1'b1, RowTyped,     '{1'b0, 8'h00, 4'd0, 1'b1, StatusBad}},
    '{8'h61, 1'b0, RowPredicted, '0},
    '{8'h46, 1'b0, RowTyped,     '{1'b1, 8'hAF, 4'd0, 1'b0, StatusOk}},
    '{8'h30, 1'b0, RowPredicted, '0},
    '{8'h39, 1'b0, RowPredicted, '0},
    '{8'h40, 1'b0, RowPredicted, '0},
    '{8'h31, 1'b0, RowPredicted, '0},
    '{8'h32, 1'b0, RowPredicted, '0},
    '{8'h33, 1'b0, RowPredicted, '0},
    '{8'h5A, 1'b0, RowPredicted, '0},
    '{8'h2D, 1'b1, RowTyped,     '{1'b0, 8'h00, 4'd0, 1'b1, StatusBad}},
    '{8'h30, 1'b0, RowPredicted, '0},
    '{8'h31, 1'b0, RowPredicted, '0},
    '{8'h32, 1'b0, RowPredicted, '0},
    '{8'h33, 1'b0, RowPredicted, '0},
    '{8'h34, 1'b0, RowPredicted, '0},
    '{8'h35, 1'b0, RowPredicted, '0},
    '{8'h36, 1'b0, RowPredicted, '0},
    '{8'h37, 1'b0, RowPredicted, '0},
    '{8'h2D, 1'b1, RowTyped,     '{1'b0, 8'h00, 4'd0, 1'b1, StatusBad}},
    '{8'h66, 1'b1, RowTyped,     '{1'b0, 8'h00, 4'd0, 1'b1, StatusBad}}
  };

  logic clk;
  logic rst;

  utp_in_if  in_ch ();
  utp_out_if out_ch ();

  uuid_text_parser dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Parser model state
  logic [utp_pkg::PosWidth-1:0]   seen_chars;
  logic [3:0]                     pend_nibble;
  logic                           nibble_held;
  logic                           dash_layout;
  logic                           text_bad;
  logic [utp_pkg::CountWidth-1:0] byte_count;

  parse_res_t awaited_results [$];
  int         failures;
  int         chars_sent;
  bit         quiet;

  function automatic void clear_parse();
    seen_chars  = '0;
    pend_nibble = '0;
    nibble_held = 1'b0;
    dash_layout = 1'b0;
    text_bad    = 1'b0;
    byte_count  = '0;
  endfunction

  // Returns 1 when the character produces a result item.
  function automatic bit decode_char(input logic [7:0] c, input logic fin,
                                     output parse_res_t r);
    logic [utp_pkg::PosWidth-1:0] pos;
    logic [utp_pkg::PosWidth-1:0] want_len;
    logic [3:0]                   nib;
    bit                           is_hex;
    bit                           dash_slot;
    bit                           emit;
    pos       = seen_chars;
    r         = '0;
    emit      = 1'b0;
    dash_slot = 1'b0;
    is_hex    = 1'b1;
    nib       = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      nib = 4'(c - 8'h37);
    end else begin
      is_hex = 1'b0;
    end

    if (pos == utp_pkg::PosFormat) begin
      dash_layout = (c == utp_pkg::DashChar);
      dash_slot   = dash_layout;
    end else if (dash_layout && (pos == utp_pkg::PosDashA || pos == utp_pkg::PosDashB ||
                                 pos == utp_pkg::PosDashC)) begin
      dash_slot = 1'b1;
      if (c != utp_pkg::DashChar) text_bad = 1'b1;
    end

    if (!dash_slot) begin
      if (!is_hex) begin
        text_bad = 1'b1;
      end else if (!nibble_held) begin
        pend_nibble = nib;
        nibble_held = 1'b1;
      end else begin
        nibble_held = 1'b0;
        if (byte_count >= utp_pkg::UuidBytes) begin
          text_bad = 1'b1;
        end else begin
          // once the text is bad, pairs still count but are not emitted
          if (!text_bad) begin
            emit         = 1'b1;
            r.byte_valid = 1'b1;
            r.byte_value = {pend_nibble, nib};
            r.byte_index = byte_count[3:0];
          end
          byte_count = byte_count + 1'b1;
        end
      end
    end

    seen_chars = (pos < utp_pkg::PosSaturate) ? pos + 1'b1 : utp_pkg::PosSaturate;

    if (fin) begin
      want_len   = dash_layout ? utp_pkg::LenDashed : utp_pkg::LenPlain;
      r.done_res = 1'b1;
      r.status   = (text_bad || (pos + 1'b1) != want_len ||
                    byte_count != utp_pkg::UuidBytes || nibble_held) ? StatusBad : StatusOk;
      clear_parse();
    end
    return emit || fin;
  endfunction

  function automatic logic [7:0] hex_char();
    int n;
    n = $urandom_range(0, 15);
    if (n < 10) return 8'(8'h30 + n);
    if ($urandom_range(0, 1) != 0) return 8'(8'h61 + n - 10);
    return 8'(8'h41 + n - 10);
  endfunction

  task automatic report_mismatch(input string why, input parse_res_t exp_r,
                                 input parse_res_t got_r);
    failures++;
    if (failures <= MaxReported) begin
      $display({"%0t: %s: expected bv=%0b val=%02h idx=%0d done=%0b st=%0b, ",
                "got bv=%0b val=%02h idx=%0d done=%0b st=%0b"},
               $time, why, exp_r.byte_valid, exp_r.byte_value, exp_r.byte_index,
               exp_r.done_res, exp_r.status, got_r.byte_valid, got_r.byte_value,
               got_r.byte_index, got_r.done_res, got_r.status);
    end
  endtask

  // Offer one character and wait until it is taken.
  task automatic send_char(input logic [7:0] c, input logic fin);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.character  <= c;
    in_ch.final_char <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    chars_sent++;
    quiet = (chars_sent >= QuietFrom && chars_sent < QuietTo);
  endtask

  task automatic send_and_predict(input logic [7:0] c, input logic fin);
    parse_res_t r;
    send_char(c, fin);
    if (decode_char(c, fin, r)) awaited_results.push_back(r);
  endtask

  // Output side: check, then pick ready for the next cycle.
  initial begin
    parse_res_t got_r;
    parse_res_t exp_r;
    int         hold_left;
    bit         held_once;
    hold_left = 0;
    held_once = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got_r = '{out_ch.byte_valid, out_ch.byte_value, out_ch.byte_index,
                  out_ch.done_res, out_ch.status};
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got_r);
        end else begin
          exp_r = awaited_results.pop_front();
          if (got_r !== exp_r) report_mismatch("wrong result", exp_r, got_r);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!held_once && chars_sent >= HoldAt) begin
        // long back-pressure while the sender keeps going
        held_once = 1'b1;
        hold_left = HoldCycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || $urandom_range(0, 99) >= 10;
      end
    end
  end

  initial begin
    logic [7:0] text [$];
    int         pick;
    int         cut;
    bit         dashed;
    parse_res_t r;
    failures   = 0;
    chars_sent = 0;
    quiet      = 1'b0;
    clear_parse();
    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.character  <= '0;
    in_ch.final_char <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      send_char(script[i].ch, script[i].fin);
      if (decode_char(script[i].ch, script[i].fin, r) || script[i].kind == RowTyped) begin
        awaited_results.push_back(script[i].kind == RowTyped ? script[i].res : r);
      end
    end

    while (chars_sent < NumItems) begin
      text.delete();
      pick   = $urandom_range(0, 99);
      dashed = $urandom_range(0, 99) < 60;
      if (pick < 92) begin
        for (int i = 0; i < (dashed ? 36 : 32); i++) begin
          text.push_back((dashed && (i == utp_pkg::PosFormat || i == utp_pkg::PosDashA ||
                                     i == utp_pkg::PosDashB || i == utp_pkg::PosDashC)) ?
                         utp_pkg::DashChar : hex_char());
        end
        if (pick >= 68) begin
          case ($urandom_range(0, 3))
            0: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
              cut = $urandom_range(1, text.size() - 1);
              while (text.size() > cut) void'(text.pop_back());
            end
            // extra hex characters can push past sixteen bytes and the saturating position
            2: repeat ($urandom_range(1, 8)) text.push_back(hex_char());
            default: begin
              if (dashed) text[utp_pkg::PosDashB] = hex_char();
              else text[utp_pkg::PosFormat] = utp_pkg::DashChar;
            end
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 40)) begin
          text.push_back($urandom_range(0, 1) ? hex_char() : 8'($urandom_range(0, 255)));
        end
      end
      foreach (text[i]) send_and_predict(text[i], i == text.size() - 1);
    end
    in_ch.valid <= 1'b0;

    for (int k = 0; k < 20000 && awaited_results.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (awaited_results.size() != 0) begin
      failures += awaited_results.size();
      $display("%0d expected results never arrived", awaited_results.size());
    end
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
